// ===== sv/odo_pkg.sv =====
// Shared types, constants and helper functions for the wheel odometry block.
package odo_pkg;

  // Configuration register indexes
  localparam logic REG_MPC = 1'b0;
  localparam logic REG_WB  = 1'b1;

  localparam logic [15:0] MPC_RESET = 16'd2687;
  localparam logic [19:0] WB_RESET  = 20'd9175;

  // Fixed-point constants
  localparam logic signed [18:0] HEAD_K4     = 19'sd166886;  // 65536/(2*pi) in Q.4
  localparam logic signed [20:0] USEC_PER_S  = 21'sd1000000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [47:0] TRAVEL_LIM  = 48'sd4294967295;
  localparam logic signed [48:0] DIFF_LIM    = 49'sd1099511627776;
  localparam logic signed [62:0] TURN_LIM    = 63'sd8589934592;

  // Divider geometry
  localparam int DIV_NW = 62;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 6;

  localparam int ITER_W = 5;

  typedef enum logic [1:0] {
    DIV_STEP,
    DIV_TURN,
    DIV_LIN,
    DIV_ANG
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL1,
    S_MIX,
    S_MUL2,
    S_DSTEP,
    S_WSTEP,
    S_CINIT,
    S_CROT,
    S_PMUL,
    S_PACC,
    S_DTURN,
    S_WTURN,
    S_MUL3,
    S_DLIN,
    S_WLIN,
    S_DANG,
    S_WANG,
    S_DONE
  } odo_state_t;

  typedef struct packed {
    logic              load;
    logic              mul1;
    logic              mix;
    logic              mul2;
    logic              div_start;
    logic              div_take;
    div_sel_t          div_sel;
    logic              cinit;
    logic              crot;
    logic [ITER_W-1:0] iter;
    logic              pmul;
    logic              pacc;
    logic              mul3;
    logic              out_load;
  } odo_cmd_t;

  typedef struct packed {
    logic div_done;
    logic et_zero;
  } odo_sts_t;

  // Arctangent of 2^-i at 2^32 units per turn
  function automatic logic signed [33:0] atan_f(input logic [ITER_W-1:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:    v = 34'sh020000000;
      5'd1:    v = 34'sh012E4051E;
      5'd2:    v = 34'sh009FB385B;
      5'd3:    v = 34'sh0051111D4;
      5'd4:    v = 34'sh0028B0D43;
      5'd5:    v = 34'sh00145D7E1;
      5'd6:    v = 34'sh000A2F61E;
      5'd7:    v = 34'sh000517C55;
      5'd8:    v = 34'sh00028BE53;
      5'd9:    v = 34'sh000145F2F;
      5'd10:   v = 34'sh0000A2F98;
      5'd11:   v = 34'sh0000517CC;
      5'd12:   v = 34'sh000028BE6;
      5'd13:   v = 34'sh0000145F3;
      5'd14:   v = 34'sh00000A2FA;
      5'd15:   v = 34'sh00000517D;
      5'd16:   v = 34'sh0000028BE;
      5'd17:   v = 34'sh00000145F;
      5'd18:   v = 34'sh000000A30;
      5'd19:   v = 34'sh000000518;
      5'd20:   v = 34'sh00000028C;
      5'd21:   v = 34'sh000000146;
      5'd22:   v = 34'sh0000000A3;
      5'd23:   v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [62:0] v);
    logic signed [31:0] r;
    if (v > 63'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -63'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/odo_div.sv =====
// Radix-2 restoring divider with round-half-away-from-zero on a signed numerator.
module odo_div import odo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start_i,
  input  logic signed [DIV_NW-1:0] num_i,
  input  logic        [DIV_DW-1:0] den_i,
  output logic                     done_o,
  output logic signed [DIV_NW:0]   quo_o
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              neg_r;
  logic [DIV_NW-1:0] dvd_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] mag;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   shifted;

  always_comb begin
    mag = (num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i))
          + DIV_NW'(den_i >> 1);
    shifted = {rem_r, dvd_r[DIV_NW-1]};
    trial = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= mag;
      rem_r <= '0;
      den_r <= den_i;
      neg_r <= num_i[DIV_NW-1];
    end else if (busy_r) begin
      if (!trial[DIV_DW]) begin
        rem_r <= trial[DIV_DW-1:0];
        dvd_r <= {dvd_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIV_DW-1:0];
        dvd_r <= {dvd_r[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_r;
  assign quo_o = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

// ===== sv/odo_datapath.sv =====
// Odometry datapath: config registers, pose state, multipliers, CORDIC and divider.
module odo_datapath import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  odo_cmd_t           cmd_i,
  output odo_sts_t           sts_o,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [19:0] cfg_data,
  input  logic signed [31:0] in_left_count,
  input  logic signed [31:0] in_right_count,
  input  logic        [19:0] in_elapsed_us,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic        [15:0] out_heading,
  output logic signed [31:0] out_lin_vel,
  output logic signed [31:0] out_ang_vel,
  output logic               out_time_invalid
);

  logic        [15:0] mpc_r;
  logic        [19:0] wb_r;
  logic signed [31:0] prev_left_r, prev_right_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic        [15:0] acc_h_r;

  logic signed [31:0] dl_r, dr_r;
  logic        [19:0] et_r;
  logic signed [47:0] sl_r, sr_r;
  logic signed [32:0] dc_r;
  logic signed [41:0] diff_r;
  logic signed [61:0] hk_r, lk_r, ak_r;
  logic        [15:0] sh_r;
  logic signed [34:0] turn_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [66:0] px_r, py_r;
  logic signed [31:0] lin_r, ang_r;

  logic        [19:0] wb_eff;
  logic signed [48:0] sum_w, dif_w;
  logic signed [47:0] half_w;
  logic signed [32:0] dc_nxt;
  logic signed [41:0] diff_nxt;
  logic signed [61:0] hk_nxt, lk_nxt, ak_nxt;
  logic signed [61:0] div_num;
  logic        [DIV_DW-1:0] div_den;
  logic               div_done;
  logic signed [DIV_NW:0] div_q;
  logic signed [34:0] turn_nxt;
  logic        [15:0] half_sh, mid;
  logic               flip_nxt;
  logic signed [33:0] z_init;
  logic signed [33:0] xs, ys, ang_i;
  logic signed [33:0] cx, cy;
  logic signed [66:0] px_nxt, py_nxt, px_rnd, py_rnd;

  always_comb begin
    wb_eff = (wb_r == '0) ? 20'd1 : wb_r;
    sum_w = 49'(sl_r) + 49'(sr_r);
    half_w = sum_w[48:1];
    if (half_w > TRAVEL_LIM) begin
      dc_nxt = 33'(TRAVEL_LIM);
    end else if (half_w < -TRAVEL_LIM) begin
      dc_nxt = 33'(-TRAVEL_LIM);
    end else begin
      dc_nxt = half_w[32:0];
    end
    dif_w = 49'(sr_r) - 49'(sl_r);
    if (dif_w > DIFF_LIM) begin
      diff_nxt = 42'(DIFF_LIM);
    end else if (dif_w < -DIFF_LIM) begin
      diff_nxt = 42'(-DIFF_LIM);
    end else begin
      diff_nxt = dif_w[41:0];
    end
    hk_nxt = 62'(diff_r) * 62'(HEAD_K4);
    lk_nxt = 62'(dc_r) * 62'(USEC_PER_S);
    ak_nxt = 62'(turn_r) * 62'(USEC_PER_S);

    case (cmd_i.div_sel)
      DIV_STEP: begin
        div_num = hk_r;
        div_den = {wb_eff, 4'b0};
      end
      DIV_TURN: begin
        div_num = 62'(diff_r) <<< 16;
        div_den = {4'b0, wb_eff};
      end
      DIV_LIN: begin
        div_num = lk_r;
        div_den = {4'b0, et_r};
      end
      DIV_ANG: begin
        div_num = ak_r;
        div_den = {4'b0, et_r};
      end
      default: begin
        div_num = hk_r;
        div_den = {wb_eff, 4'b0};
      end
    endcase

    if (div_q > TURN_LIM) begin
      turn_nxt = 35'(TURN_LIM);
    end else if (div_q < -TURN_LIM) begin
      turn_nxt = 35'(-TURN_LIM);
    end else begin
      turn_nxt = div_q[34:0];
    end

    // Midpoint heading: half the step, truncated toward zero
    half_sh = 16'($signed(sh_r + {15'b0, sh_r[15]}) >>> 1);
    mid = acc_h_r + half_sh;
    flip_nxt = (mid > 16'h4000) && (mid <= 16'hC000);
    z_init = 34'($signed({mid[15] ^ flip_nxt, mid[14:0], 16'b0}));

    xs = x_r >>> cmd_i.iter;
    ys = y_r >>> cmd_i.iter;
    ang_i = atan_f(cmd_i.iter);

    cx = flip_r ? -x_r : x_r;
    cy = flip_r ? -y_r : y_r;
    px_nxt = 67'(dc_r) * 67'(cx);
    py_nxt = 67'(dc_r) * 67'(cy);
    px_rnd = px_r + 67'sd536870912;
    py_rnd = py_r + 67'sd536870912;
  end

  odo_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.et_zero = (et_r == '0);

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpc_r <= MPC_RESET;
      wb_r <= WB_RESET;
      prev_left_r <= '0;
      prev_right_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_h_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MPC: mpc_r <= cfg_data[15:0];
          REG_WB:  wb_r <= cfg_data;
          default: mpc_r <= mpc_r;
        endcase
      end
      if (cmd_i.load) begin
        prev_left_r <= in_left_count;
        prev_right_r <= in_right_count;
      end
      if (cmd_i.pacc) begin
        acc_x_r <= acc_x_r + px_rnd[61:30];
        acc_y_r <= acc_y_r + py_rnd[61:30];
        acc_h_r <= acc_h_r + sh_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      dl_r <= in_left_count - prev_left_r;
      dr_r <= in_right_count - prev_right_r;
      et_r <= in_elapsed_us;
    end
    if (cmd_i.mul1) begin
      sl_r <= 48'(dl_r) * 48'($signed({1'b0, mpc_r}));
      sr_r <= 48'(dr_r) * 48'($signed({1'b0, mpc_r}));
    end
    if (cmd_i.mix) begin
      dc_r <= dc_nxt;
      diff_r <= diff_nxt;
    end
    if (cmd_i.mul2) begin
      hk_r <= hk_nxt;
      lk_r <= lk_nxt;
    end
    if (cmd_i.mul3) begin
      ak_r <= ak_nxt;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_STEP: sh_r <= div_q[15:0];
        DIV_TURN: turn_r <= turn_nxt;
        DIV_LIN:  lin_r <= sat32_f(div_q);
        DIV_ANG:  ang_r <= sat32_f(div_q);
        default:  sh_r <= div_q[15:0];
      endcase
    end
    if (cmd_i.cinit) begin
      x_r <= CORDIC_GAIN;
      y_r <= '0;
      z_r <= z_init;
      flip_r <= flip_nxt;
    end
    if (cmd_i.crot) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang_i;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang_i;
      end
    end
    if (cmd_i.pmul) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (cmd_i.pacc) begin
      lin_r <= '0;
      ang_r <= '0;
    end
    if (cmd_i.out_load) begin
      out_pos_x <= acc_x_r;
      out_pos_y <= acc_y_r;
      out_heading <= acc_h_r;
      out_lin_vel <= lin_r;
      out_ang_vel <= ang_r;
      out_time_invalid <= (et_r == '0);
    end
  end

endmodule

// ===== sv/odo_ctrl.sv =====
// Odometry sequencer: steps the datapath through one sample and owns the handshakes.
module odo_ctrl import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  odo_sts_t sts_i,
  output odo_cmd_t cmd_o
);

  odo_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MIX;
      S_MIX:   state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DSTEP;
      S_DSTEP: state_nxt = S_WSTEP;
      S_WSTEP: if (sts_i.div_done) state_nxt = S_CINIT;
      S_CINIT: state_nxt = S_CROT;
      S_CROT:  if (iter_r == ITER_W'(CORDIC_STEPS - 1)) state_nxt = S_PMUL;
      S_PMUL:  state_nxt = S_PACC;
      S_PACC:  state_nxt = sts_i.et_zero ? S_DONE : S_DTURN;
      S_DTURN: state_nxt = S_WTURN;
      S_WTURN: if (sts_i.div_done) state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_DLIN;
      S_DLIN:  state_nxt = S_WLIN;
      S_WLIN:  if (sts_i.div_done) state_nxt = S_DANG;
      S_DANG:  state_nxt = S_WANG;
      S_WANG:  if (sts_i.div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.iter = iter_r;
    cmd_o.div_sel = DIV_STEP;
    iter_nxt = iter_r;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd_o.load = in_valid;
      end
      S_MUL1:  cmd_o.mul1 = 1'b1;
      S_MIX:   cmd_o.mix = 1'b1;
      S_MUL2:  cmd_o.mul2 = 1'b1;
      S_DSTEP: cmd_o.div_start = 1'b1;
      S_WSTEP: cmd_o.div_take = sts_i.div_done;
      S_CINIT: begin
        cmd_o.cinit = 1'b1;
        iter_nxt = '0;
      end
      S_CROT: begin
        cmd_o.crot = 1'b1;
        iter_nxt = iter_r + 1'b1;
      end
      S_PMUL:  cmd_o.pmul = 1'b1;
      S_PACC:  cmd_o.pacc = 1'b1;
      S_DTURN: begin
        cmd_o.div_sel = DIV_TURN;
        cmd_o.div_start = 1'b1;
      end
      S_WTURN: begin
        cmd_o.div_sel = DIV_TURN;
        cmd_o.div_take = sts_i.div_done;
      end
      S_MUL3:  cmd_o.mul3 = 1'b1;
      S_DLIN: begin
        cmd_o.div_sel = DIV_LIN;
        cmd_o.div_start = 1'b1;
      end
      S_WLIN: begin
        cmd_o.div_sel = DIV_LIN;
        cmd_o.div_take = sts_i.div_done;
      end
      S_DANG: begin
        cmd_o.div_sel = DIV_ANG;
        cmd_o.div_start = 1'b1;
      end
      S_WANG: begin
        cmd_o.div_sel = DIV_ANG;
        cmd_o.div_take = sts_i.div_done;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL1))
    else $error("accepted sample did not start the sequence");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still pending");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CROT) |-> (iter_r < ITER_W'(CORDIC_STEPS)))
    else $error("CORDIC iteration count out of range");
  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_take |-> $past(state_r == S_WSTEP || state_r == S_DSTEP ||
      state_r == S_WTURN || state_r == S_DTURN || state_r == S_WLIN ||
      state_r == S_DLIN || state_r == S_WANG || state_r == S_DANG))
    else $error("quotient taken without a division in flight");
`endif

endmodule

// ===== sv/diff_drive_odometry.sv =====
// Differential-drive wheel odometry top level: sequencer plus datapath.
// Each input beat carries the two cumulative encoder counts and the time since
// the previous sample; each output beat carries the updated pose (Q16.16 m,
// heading at 65536 units per turn) and the linear and angular velocity. One
// sample is worked at a time. When elapsed_us is zero the velocities are
// skipped and time_invalid is set. The work runs through the shared radix-2
// divider, which performs up to four divisions per sample (heading step, turn
// rate base, linear and angular rate), and through the CORDIC rotator at one
// iteration per cycle. The result sits in an output register, so the next
// sample is taken while the previous result waits for out_ready.
// Configuration registers: index 0 meters per count (Q0.16), index 1 wheel
// base (Q4.16, zero acts as one); write them only while the block is idle.
module diff_drive_odometry import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [19:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_left_count,
  input  logic signed [31:0] in_right_count,
  input  logic        [19:0] in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic        [15:0] out_heading,
  output logic signed [31:0] out_lin_vel,
  output logic signed [31:0] out_ang_vel,
  output logic               out_time_invalid
);

  odo_cmd_t cmd;
  odo_sts_t sts;

  // Sequencer: handshakes, state walk, CORDIC iteration count
  odo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: config, pose accumulators, multipliers, CORDIC, divider
  odo_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_left_count    (in_left_count),
    .in_right_count   (in_right_count),
    .in_elapsed_us    (in_elapsed_us),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_lin_vel      (out_lin_vel),
    .out_ang_vel      (out_ang_vel),
    .out_time_invalid (out_time_invalid)
  );

endmodule
